// File: rtl/pwshf_pkg.sv
// Package for the pulse-width span hit finder.
// Holds field widths, channel and window sizes, register indexes and the
// per-channel state entry type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pwshf_pkg;

  // Field widths fixed by the item format
  localparam int CH_W  = 10;
  localparam int BIN_W = 13;

  // Channel count and window length
  localparam int CHANNELS  = 1024;
  localparam int TIME_BINS = 8192;

  // State memory address width
  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_WIDTH = 1'b0,
    REG_MIN_SPAN  = 1'b1
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic [BIN_W-1:0] MIN_WIDTH_RST = BIN_W'(10);
  localparam logic [BIN_W-1:0] MIN_SPAN_RST  = BIN_W'(50);

  // Per-channel state held in one memory word
  typedef struct packed {
    logic             level_high;
    logic [BIN_W-1:0] pulse_start;
    logic [BIN_W-1:0] last_start;
  } entry_t;

endpackage
`default_nettype wire

// File: rtl/pulse_width_span_hit_finder_unit.sv
// Pulse-width span hit finder: top level with the per-channel state memory.
// Depends on pwshf_pkg for widths, register indexes and the entry type.
//
// Usage:
//   Input channel: in_valid/in_stall carry one sample word (channel, time_bin,
//   level). A word is taken at a rising edge with in_valid high, in_stall low.
//   Output channel: out_valid/out_stall carry one hit word (hit_channel,
//   start_time, end_time, pulse_width) for each accepted pulse; most samples
//   give no word.
//   Throughput: one sample per cycle while in_stall is low. Each sample does
//   one read-modify-write of its channel's entry in the state memory; a sample
//   directly behind one on the same channel takes the written data forwarded.
//   Samples are registered in the processing stage, hit words in the output
//   register. Stall: while out_stall holds a waiting hit word, a sample in
//   the processing stage halts there and in_stall rises; an empty stage
//   still lets a new sample in while a finished word waits.
//   Reset: rst (synchronous) sets min_width to 10 and min_span to 50, then a
//   clearing pass zeroes the state memory, one entry a cycle, for all CHANNELS
//   (1024) entries; in_stall stays high throughout. Configuration writes
//   (cfg_wr, cfg_index, cfg_data) are taken at any time, clearing included.
`timescale 1ns / 1ps
`default_nettype none
module pulse_width_span_hit_finder_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // sample input
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [pwshf_pkg::CH_W-1:0]          channel,
  input  wire logic [pwshf_pkg::BIN_W-1:0]         time_bin,
  input  wire logic                                level,
  // hit output
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [pwshf_pkg::CH_W-1:0]               hit_channel,
  output logic [pwshf_pkg::BIN_W-1:0]              start_time,
  output logic [pwshf_pkg::BIN_W-1:0]              end_time,
  output logic [pwshf_pkg::BIN_W-1:0]              pulse_width,
  // configuration
  input  wire logic                                cfg_wr,
  input  wire logic [pwshf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pwshf_pkg::BIN_W-1:0]         cfg_data
);

  localparam int AW = pwshf_pkg::ADDR_W;
  localparam int BW = pwshf_pkg::BIN_W;

  // Configuration registers
  logic [BW-1:0] min_width;
  logic [BW-1:0] min_span;

  // Clearing pass
  logic          clearing;
  logic [AW:0]   clr_cnt;

  // State memory
  pwshf_pkg::entry_t mem [pwshf_pkg::CHANNELS];
  pwshf_pkg::entry_t rd_entry;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  pwshf_pkg::entry_t mem_wdata;

  // Processing stage
  logic                      s1_valid;
  logic [pwshf_pkg::CH_W-1:0] s1_channel;
  logic [BW-1:0]             s1_time;
  logic                      s1_level;
  logic                      s1_go;
  logic                      s1_in_range;
  logic                      s1_we;
  logic [AW-1:0]             s1_addr;
  pwshf_pkg::entry_t         cur;
  pwshf_pkg::entry_t         nxt;
  logic                      hit;
  logic [BW-1:0]             width;
  logic [BW-1:0]             span;

  logic          in_fire;
  logic [AW-1:0] in_addr;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= pwshf_pkg::MIN_WIDTH_RST;
      min_span  <= pwshf_pkg::MIN_SPAN_RST;
    end else if (cfg_wr) begin
      unique case (pwshf_pkg::cfg_reg_t'(cfg_index))
        pwshf_pkg::REG_MIN_WIDTH: min_width <= cfg_data;
        pwshf_pkg::REG_MIN_SPAN:  min_span  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sweep the memory once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == (AW+1)'(pwshf_pkg::CHANNELS - 1)) begin
        clearing <= 1'b0;
      end
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Handshake on the input side
  assign s1_go    = !out_valid || !out_stall;
  assign in_stall = clearing || (s1_valid && !s1_go);
  assign in_fire  = in_valid && !in_stall;
  assign in_addr  = AW'(channel);

  // Advance the processing stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || s1_go) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_channel <= channel;
      s1_time    <= time_bin;
      s1_level   <= level;
    end
  end

  // Read the entry, forwarding a write to the same channel in this cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (s1_we && (s1_addr == in_addr)) begin
        rd_entry <= nxt;
      end else begin
        rd_entry <= mem[in_addr];
      end
    end
  end

  // Update the entry and decide on a hit
  assign s1_addr     = AW'(s1_channel);
  assign s1_in_range = (32'(s1_channel) < pwshf_pkg::CHANNELS) &&
                       (32'(s1_time) < pwshf_pkg::TIME_BINS);
  assign s1_we       = s1_valid && s1_go && s1_in_range;

  always_comb begin
    cur = rd_entry;
    if (s1_time == '0) begin
      cur = '0;
    end
    nxt   = cur;
    hit   = 1'b0;
    width = s1_time - cur.pulse_start;
    span  = cur.pulse_start - cur.last_start;
    if (s1_level && !cur.level_high) begin
      nxt.level_high  = 1'b1;
      nxt.pulse_start = s1_time;
    end else if (!s1_level && cur.level_high) begin
      nxt.level_high = 1'b0;
      if ((width >= min_width) && ((span >= min_span) || (cur.last_start == '0))) begin
        hit            = 1'b1;
        nxt.last_start = cur.pulse_start;
      end
    end
  end

  // Write port: clearing pass or write-back
  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt[AW-1:0];
      mem_wdata = '0;
    end else begin
      mem_we    = s1_we;
      mem_waddr = s1_addr;
      mem_wdata = nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Output register: hold while stalled, load a hit word when the stage moves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_we && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_we && hit) begin
      hit_channel <= s1_channel;
      start_time  <= cur.pulse_start;
      end_time    <= s1_time;
      pulse_width <= width;
    end
  end

`ifndef SYNTH
  // A halted stage keeps its sample
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_channel) && $stable(s1_time)))
    else $error("processing stage lost its sample while halted");

  // Reported width matches the reported edges
  a_width_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pulse_width == BW'(end_time - start_time)))
    else $error("pulse width disagrees with start and end times");

  // Nothing moves through the pipe during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s1_valid && !out_valid))
    else $error("work in flight during the clearing pass");
`endif

endmodule
`default_nettype wire

// File: test/tb_pulse_width_span_hit_finder_unit.sv
// Testbench for the pulse-width span hit finder: predicts hit words per channel
// and checks every output word in order. Depends on pwshf_pkg and the RTL top.
`timescale 1ns / 1ps
module tb_pulse_width_span_hit_finder_unit;
  import pwshf_pkg::*;

  localparam int POOL_SIZE    = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [CH_W-1:0]  chan;
    logic [BIN_W-1:0] tbin;
    logic             lvl;
  } sample_t;

  typedef struct packed {
    logic [CH_W-1:0]  chan;
    logic [BIN_W-1:0] start;
    logic [BIN_W-1:0] stop;
    logic [BIN_W-1:0] width;
  } hit_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // Per-channel pulse tracker and the queue of hit words still to come
  class pulse_hit_scoreboard;
    bit               level_high [CHANNELS];
    bit [BIN_W-1:0]   pulse_start [CHANNELS];
    bit [BIN_W-1:0]   last_start [CHANNELS];
    bit [BIN_W-1:0]   min_width = MIN_WIDTH_RST;
    bit [BIN_W-1:0]   min_span = MIN_SPAN_RST;
    hit_t             pending_hits[$];
    int               mismatches = 0;

    function void set_reg(cfg_reg_t idx, bit [BIN_W-1:0] value);
      case (idx)
        REG_MIN_WIDTH: min_width = value;
        REG_MIN_SPAN:  min_span = value;
        default: ;
      endcase
    endfunction

    // Update the channel and queue a hit word when a pulse closes and passes
    function void note_sample(sample_t s);
      bit [BIN_W-1:0] width;
      bit [BIN_W-1:0] span;
      hit_t h;
      if (s.tbin == '0) begin
        level_high[s.chan] = 1'b0;
        pulse_start[s.chan] = '0;
        last_start[s.chan] = '0;
      end
      if (s.lvl && !level_high[s.chan]) begin
        pulse_start[s.chan] = s.tbin;
        level_high[s.chan] = 1'b1;
      end else if (!s.lvl && level_high[s.chan]) begin
        level_high[s.chan] = 1'b0;
        // wrap both differences to the bin width
        width = s.tbin - pulse_start[s.chan];
        span = pulse_start[s.chan] - last_start[s.chan];
        if (width >= min_width && (span >= min_span || last_start[s.chan] == '0)) begin
          last_start[s.chan] = pulse_start[s.chan];
          h.chan = s.chan;
          h.start = pulse_start[s.chan];
          h.stop = s.tbin;
          h.width = width;
          pending_hits.push_back(h);
        end
      end
    endfunction

    function void compare(string field, logic [BIN_W-1:0] want, logic [BIN_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_hit(hit_t got);
      hit_t want;
      if (pending_hits.size() == 0) begin
        mismatches++;
        $display("%0t: expected no hit, got channel %0d start %0d end %0d width %0d",
                 $time, got.chan, got.start, got.stop, got.width);
        return;
      end
      want = pending_hits.pop_front();
      compare("hit_channel", BIN_W'(want.chan), BIN_W'(got.chan));
      compare("start_time", want.start, got.start);
      compare("end_time", want.stop, got.stop);
      compare("pulse_width", want.width, got.width);
    endfunction
  endclass

  logic               clk = 0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [CH_W-1:0]    channel;
  logic [BIN_W-1:0]   time_bin;
  logic               level;
  logic               out_valid;
  logic               out_stall;
  logic [CH_W-1:0]    hit_channel;
  logic [BIN_W-1:0]   start_time;
  logic [BIN_W-1:0]   end_time;
  logic [BIN_W-1:0]   pulse_width;
  logic               cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BIN_W-1:0]   cfg_data;

  pulse_hit_scoreboard hits;
  sample_t      directed_words[$];
  logic [CH_W-1:0] pool_ch [POOL_SIZE];
  int           cursor [POOL_SIZE];
  bit           gen_lvl [POOL_SIZE];
  int           burst_left = 0;
  int           cycle_count = 0;
  stall_mode_t  stall_mode = STALL_NONE;
  int           stall_left = 0;

  pulse_width_span_hit_finder_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .channel(channel), .time_bin(time_bin), .level(level),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit_channel(hit_channel), .start_time(start_time),
    .end_time(end_time), .pulse_width(pulse_width),
    .cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Check accepted hit words, then pick the next stall state
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      hits.check_hit(hit_t'{hit_channel, start_time, end_time, pulse_width});
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= (stall_left % 5 < 2);
      default:        out_stall <= 1'b0;
    endcase
  end

  // Give up on a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_pulse_width_span_hit_finder_unit NOT OK");
    $finish;
  end

  function void queue_word(int ch, int tb, bit lv);
    directed_words.push_back(sample_t'{CH_W'(ch), BIN_W'(tb), lv});
  endfunction

  // Hold a word until taken, with a random gap between bursts
  task automatic send_sample(sample_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    channel <= s.chan;
    time_bin <= s.tbin;
    level <= s.lvl;
    do @(posedge clk); while (in_stall);
    hits.note_sample(s);
  endtask

  // Mostly ordered pulse trains on a few channels, with some noise words
  task automatic next_random(output sample_t s);
    int k;
    int step;
    bit toggle;
    s.chan = CH_W'($urandom_range(0, CHANNELS - 1));
    s.tbin = BIN_W'($urandom_range(0, TIME_BINS - 1));
    s.lvl = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 12)
      return;
    k = $urandom_range(0, POOL_SIZE - 1);
    s.chan = pool_ch[k];
    toggle = 1'b0;
    if (cursor[k] < 0 || $urandom_range(0, 99) < 3) begin
      step = -1;
    end else begin
      toggle = ($urandom_range(0, 99) < 70);
      if (toggle && gen_lvl[k]) begin
        // aim the width around the threshold
        step = int'(hits.min_width) + int'($urandom_range(0, 6)) - 3;
        if (step < 0)
          step = 0;
      end else if (toggle) begin
        step = int'($urandom_range(1, int'(hits.min_span) + 8));
      end else begin
        step = int'($urandom_range(1, 3));
      end
      if (cursor[k] + step >= TIME_BINS)
        step = -1;
    end
    if (step < 0) begin
      cursor[k] = 0;
      s.tbin = '0;
    end else begin
      cursor[k] += step;
      s.tbin = BIN_W'(cursor[k]);
      s.lvl = toggle ? !gen_lvl[k] : gen_lvl[k];
    end
    gen_lvl[k] = s.lvl;
  endtask

  // Write registers while idle, send queued and random words, then drain
  task automatic run_phase(bit write_cfg, logic [BIN_W-1:0] w, logic [BIN_W-1:0] sp,
                           int n_random);
    sample_t s;
    if (write_cfg) begin
      cfg_wr <= 1'b1;
      cfg_index <= REG_MIN_WIDTH;
      cfg_data <= w;
      @(posedge clk);
      hits.set_reg(REG_MIN_WIDTH, w);
      cfg_index <= REG_MIN_SPAN;
      cfg_data <= sp;
      @(posedge clk);
      hits.set_reg(REG_MIN_SPAN, sp);
      cfg_wr <= 1'b0;
    end
    pool_ch[0] = '0;
    pool_ch[1] = CH_W'(CHANNELS - 1);
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i > 1)
        pool_ch[i] = CH_W'($urandom_range(0, CHANNELS - 1));
      cursor[i] = -1;
      gen_lvl[i] = 1'b0;
    end
    while (directed_words.size() != 0)
      send_sample(directed_words.pop_front());
    repeat (n_random) begin
      next_random(s);
      send_sample(s);
    end
    in_valid <= 1'b0;
    while (hits.pending_hits.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    hits = new;
    rst <= 1'b1;
    in_valid <= 1'b0;
    channel <= '0;
    time_bin <= '0;
    level <= 1'b0;
    out_stall <= 1'b0;
    cfg_wr <= 1'b0;
    cfg_index <= REG_MIN_WIDTH;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset thresholds: pass, too narrow, first pulse, ringing, span at the limit
    queue_word(0, 0, 1);
    queue_word(0, 10, 0);
    queue_word(0, 12, 1);
    queue_word(0, 20, 0);
    queue_word(0, 30, 1);
    queue_word(0, 45, 0);
    queue_word(0, 60, 1);
    queue_word(0, 75, 0);
    queue_word(0, 80, 1);
    queue_word(0, 80, 1);
    queue_word(0, 95, 0);
    // time running backwards wraps the width
    queue_word(1023, 8191, 1);
    queue_word(1023, 20, 0);
    // restart while high drops the pulse; a rise at bin 0 is taken
    queue_word(1023, 0, 1);
    queue_word(1023, 0, 0);
    queue_word(1023, 100, 1);
    queue_word(1023, 0, 0);
    queue_word(5, 7, 0);
    queue_word(512, 8191, 1);
    queue_word(512, 0, 0);
    run_phase(1'b0, MIN_WIDTH_RST, MIN_SPAN_RST, 200);

    // Zero thresholds: a pulse closed in its own bin is a hit
    queue_word(7, 0, 0);
    queue_word(7, 100, 1);
    queue_word(7, 100, 0);
    run_phase(1'b1, '0, '0, 150);

    // Top thresholds: only a full-window pulse passes
    queue_word(3, 0, 1);
    queue_word(3, 8191, 0);
    run_phase(1'b1, '1, '1, 60);

    run_phase(1'b1, BIN_W'(4), BIN_W'(20), 200);
    run_phase(1'b1, BIN_W'($urandom_range(1, 40)), BIN_W'($urandom_range(1, 200)), 200);

    if (hits.mismatches == 0 && hits.pending_hits.size() == 0)
      $display("tb_pulse_width_span_hit_finder_unit OK");
    else
      $display("tb_pulse_width_span_hit_finder_unit NOT OK");
    $finish;
  end

endmodule
